@@ hdl/inm_pkg.sv @@
// Package: shared types, constants and tables for the intensity mean-difference block.
package inm_pkg;

  localparam int NUM_TRANSFORMS_DEF = 64;
  localparam int COUNT_BITS_DEF     = 24;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [21:0] PI_Q16      = 22'sd205887;
  localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [64:0] MEAN_MAX    = 65'sd140737488355327;
  localparam logic signed [64:0] MEAN_MIN    = -65'sd140737488355328;
  localparam logic signed [63:0] SUM_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN     = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SAMPLE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         norm_index;
    logic signed [24:0] x_offset;
    logic signed [24:0] y_offset;
    logic signed [18:0] theta;
    logic signed [19:0] shear;
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic [15:0]        x_raw;
    logic [15:0]        y_raw;
  } item_t;

  typedef struct packed {
    logic signed [24:0] x_offset;
    logic signed [24:0] y_offset;
    logic signed [17:0] cos_v;
    logic signed [17:0] sin_v;
    logic signed [19:0] shear;
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
  } entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOAD,
    B_MUL1,
    B_MUL2,
    B_MUL3,
    B_XDIV,
    B_XWAIT,
    B_YDIV,
    B_YWAIT,
    B_ACC,
    B_MDIV,
    B_MWAIT,
    B_OUT
  } back_state_t;

  function automatic logic signed [21:0] atan_q16(input logic [3:0] i);
    logic signed [21:0] r;
    unique case (i)
      4'd0:  r = 22'sd51472;
      4'd1:  r = 22'sd30385;
      4'd2:  r = 22'sd16055;
      4'd3:  r = 22'sd8150;
      4'd4:  r = 22'sd4091;
      4'd5:  r = 22'sd2047;
      4'd6:  r = 22'sd1024;
      4'd7:  r = 22'sd512;
      4'd8:  r = 22'sd256;
      4'd9:  r = 22'sd128;
      4'd10: r = 22'sd64;
      4'd11: r = 22'sd32;
      4'd12: r = 22'sd16;
      4'd13: r = 22'sd8;
      4'd14: r = 22'sd4;
      default: r = 22'sd2;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/inm_front.sv @@
// Front end: accept and classify input items, queue them for the back end.
module inm_front #(
  parameter int NUM_TRANSFORMS = inm_pkg::NUM_TRANSFORMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [5:0]          norm_index,
  input  logic signed [24:0]  x_offset,
  input  logic signed [24:0]  y_offset,
  input  logic signed [18:0]  theta,
  input  logic signed [19:0]  shear,
  input  logic signed [31:0]  x_scale,
  input  logic signed [31:0]  y_scale,
  input  logic [15:0]         x_raw,
  input  logic [15:0]         y_raw,
  output logic                q_valid,
  input  logic                q_ready,
  output inm_pkg::item_t      q_item
);
  import inm_pkg::*;

  item_t      fifo [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       in_range, keep, push, pop;
  item_t      cls;

  assign in_ready = (count != 2'd2);
  assign in_range = (32'(norm_index) < NUM_TRANSFORMS);

  always_comb begin
    cls = '{op: OP_FINISH, norm_index: norm_index, x_offset: x_offset, y_offset: y_offset,
            theta: theta, shear: shear, x_scale: x_scale, y_scale: y_scale,
            x_raw: x_raw, y_raw: y_raw};
    keep = 1'b0;
    unique case (kind)
      KIND_LOAD: begin
        cls.op = OP_LOAD;
        keep   = in_range;
      end
      KIND_SAMPLE: begin
        cls.op = OP_SAMPLE;
        keep   = in_range;
      end
      KIND_FINISH: begin
        cls.op = OP_FINISH;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push    = in_valid && in_ready && keep;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hdl/inm_cordic.sv @@
// Iterative CORDIC: cosine and sine of a Q3.16 angle, one rotation per cycle.
module inm_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [18:0] theta,
  output logic               done,
  output logic signed [17:0] cos_v,
  output logic signed [17:0] sin_v
);
  import inm_pkg::*;

  logic signed [33:0] x, y;
  logic signed [21:0] z, z_in;
  logic [3:0]         step;
  logic               running, flip;
  logic signed [33:0] dx, dy, xf, yf, xr, yr;

  assign z_in = 22'(theta);
  assign dx   = y >>> step;
  assign dy   = x >>> step;

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      step <= '0;
      if (z_in > HALF_PI_Q16) begin
        z    <= z_in - PI_Q16;
        flip <= 1'b1;
      end else if (z_in < -HALF_PI_Q16) begin
        z    <= z_in + PI_Q16;
        flip <= 1'b1;
      end else begin
        z    <= z_in;
        flip <= 1'b0;
      end
    end else if (running) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_q16(step);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_q16(step);
      end
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (step == 4'(CORDIC_STEPS - 1));
      if (start) begin
        running <= 1'b1;
      end else if (running && (step == 4'(CORDIC_STEPS - 1))) begin
        running <= 1'b0;
      end
    end
  end

  assign xf    = flip ? -x : x;
  assign yf    = flip ? -y : y;
  assign xr    = (xf + 34'sd8192) >>> 14;
  assign yr    = (yf + 34'sd8192) >>> 14;
  assign cos_v = xr[17:0];
  assign sin_v = yr[17:0];

endmodule

@@ hdl/inm_div.sv @@
// Restoring divider: 64-bit unsigned quotient, one bit per cycle.
module inm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem, dvs;
  logic [6:0]  cnt;
  logic        running;
  logic [65:0] trial;

  assign trial    = {1'b0, rem, quotient[63]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
      cnt      <= '0;
    end else if (running) begin
      if (!trial[65]) begin
        rem      <= trial[63:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= {rem[62:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end
      cnt <= cnt + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == 7'd63);
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == 7'd63)) begin
        running <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/inm_back.sv @@
// Back end: transform table, normalization datapath, accumulator and result register.
module inm_back #(
  parameter int NUM_TRANSFORMS = inm_pkg::NUM_TRANSFORMS_DEF,
  parameter int COUNT_BITS     = inm_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [16:0]            min_abs_scale,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  inm_pkg::item_t         q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [47:0]     mean_difference,
  output logic [COUNT_BITS-1:0]  samples_used,
  output logic                   saturated
);
  import inm_pkg::*;

  localparam int AW = (NUM_TRANSFORMS > 1) ? $clog2(NUM_TRANSFORMS) : 1;

  back_state_t state, state_next;

  entry_t mem [NUM_TRANSFORMS];
  entry_t ent, wr_entry;
  item_t  cur;
  logic   mem_we;

  logic signed [44:0] p1, p2, p3, p4;
  logic signed [45:0] rx, ry;
  logic signed [63:0] sx, xn, yn;
  logic signed [63:0] sum;
  logic [COUNT_BITS-1:0] count;
  logic               ovf;
  logic signed [64:0] mean_full;

  logic               cordic_start, cordic_done;
  logic signed [17:0] cos_v, sin_v;
  logic               div_start, div_done;
  logic [63:0]        div_a, div_b, div_q;
  logic               div_neg;

  logic signed [26:0] tx, ty;
  logic signed [32:0] ax, ay;
  logic               scale_ok;
  logic signed [65:0] shr_ry;
  logic signed [53:0] ydnd;
  logic signed [63:0] qs, d;
  logic signed [64:0] s65;
  logic signed [64:0] qm;
  logic               pop;

  assign pop     = q_valid && q_ready;
  assign q_ready = (state == B_IDLE);

  inm_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .theta(q_item.theta),
    .done(cordic_done), .cos_v(cos_v), .sin_v(sin_v)
  );

  inm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  assign wr_entry = '{x_offset: cur.x_offset, y_offset: cur.y_offset, cos_v: cos_v,
                      sin_v: sin_v, shear: cur.shear, x_scale: cur.x_scale,
                      y_scale: cur.y_scale};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cur.norm_index)] <= wr_entry;
    end
    if (pop) begin
      ent <= mem[AW'(q_item.norm_index)];
    end
  end

  assign tx = 27'($signed({1'b0, cur.x_raw, 8'h00})) - 27'(ent.x_offset);
  assign ty = 27'($signed({1'b0, cur.y_raw, 8'h00})) - 27'(ent.y_offset);
  assign ax = ent.x_scale[31] ? -33'(ent.x_scale) : 33'(ent.x_scale);
  assign ay = ent.y_scale[31] ? -33'(ent.y_scale) : 33'(ent.y_scale);
  assign scale_ok = (ax > 33'($signed({1'b0, min_abs_scale}))) &&
                    (ay > 33'($signed({1'b0, min_abs_scale})));
  assign shr_ry = 66'(ent.shear) * 66'(ry);
  assign ydnd   = 54'(ry) <<< 8;
  assign qs     = div_neg ? -div_q : div_q;
  assign qm     = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign d      = yn - xn;
  assign s65    = 65'(sum) + 65'(d);

  always_comb begin
    state_next   = state;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    div_a        = '0;
    div_b        = '0;
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          unique case (q_item.op)
            OP_LOAD: begin
              cordic_start = 1'b1;
              state_next   = B_LOAD;
            end
            OP_SAMPLE: state_next = B_MUL1;
            default:   state_next = B_MDIV;
          endcase
        end
      end
      B_LOAD: begin
        if (cordic_done) begin
          mem_we     = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_MUL1:  state_next = scale_ok ? B_MUL2 : B_IDLE;
      B_MUL2:  state_next = B_MUL3;
      B_MUL3:  state_next = B_XDIV;
      B_XDIV: begin
        div_start  = 1'b1;
        div_a      = sx[63] ? 64'(-sx) : 64'(sx);
        div_b      = 64'(ax) << 8;
        state_next = B_XWAIT;
      end
      B_XWAIT: if (div_done) state_next = B_YDIV;
      B_YDIV: begin
        div_start  = 1'b1;
        div_a      = 64'(ydnd[53] ? -ydnd : ydnd);
        div_b      = 64'(ay);
        state_next = B_YWAIT;
      end
      B_YWAIT: if (div_done) state_next = B_ACC;
      B_ACC:   state_next = B_IDLE;
      B_MDIV: begin
        if (count != '0) begin
          div_start  = 1'b1;
          div_a      = sum[63] ? 64'(-sum) : 64'(sum);
          div_b      = 64'(count);
          state_next = B_MWAIT;
        end else begin
          state_next = B_OUT;
        end
      end
      B_MWAIT: if (div_done) state_next = B_OUT;
      B_OUT:   if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
    unique case (state)
      B_MUL1: begin
        p1 <= 45'(ent.cos_v) * 45'(tx);
        p2 <= 45'(ent.sin_v) * 45'(ty);
        p3 <= 45'(ent.cos_v) * 45'(ty);
        p4 <= 45'(ent.sin_v) * 45'(tx);
      end
      B_MUL2: begin
        rx <= 46'(p1) + 46'(p2);
        ry <= 46'(p3) - 46'(p4);
      end
      B_MUL3: sx <= 64'((66'(rx) <<< 16) - shr_ry);
      B_XDIV: div_neg <= sx[63] ^ ent.x_scale[31];
      B_XWAIT: if (div_done) xn <= qs;
      B_YDIV: div_neg <= ry[45] ^ ent.y_scale[31];
      B_YWAIT: if (div_done) yn <= qs;
      B_MDIV: begin
        div_neg   <= sum[63];
        mean_full <= '0;
      end
      B_MWAIT: if (div_done) mean_full <= qm;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_ACC) begin
        if (s65[64] != s65[63]) begin
          sum <= s65[64] ? SUM_MIN : SUM_MAX;
          ovf <= 1'b1;
        end else begin
          sum <= s65[63:0];
        end
        if (count == '1) begin
          ovf <= 1'b1;
        end else begin
          count <= count + COUNT_BITS'(1);
        end
      end
      if (state == B_OUT && (!out_valid || out_ready)) begin
        out_valid    <= 1'b1;
        samples_used <= count;
        if (mean_full > MEAN_MAX) begin
          mean_difference <= MEAN_MAX[47:0];
          saturated       <= 1'b1;
        end else if (mean_full < MEAN_MIN) begin
          mean_difference <= MEAN_MIN[47:0];
          saturated       <= 1'b1;
        end else begin
          mean_difference <= mean_full[47:0];
          saturated       <= ovf;
        end
        sum   <= '0;
        count <= '0;
        ovf   <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/intensity_normalize_mean_diff.sv @@
// Top level: intensity normalization mean-difference block.
// Input channel (in_valid/in_ready) carries one item per transfer: kind selects
// load (store a transform), sample (normalize x_raw/y_raw and accumulate yn-xn)
// or finish (emit the mean and clear the run). Kind 3 is dropped.
// Output channel (out_valid/out_ready) carries one result per finish item:
// mean_difference, samples_used and saturated.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes min_abs_scale; always ready.
// Items pass through a two-entry queue into a sequential back end, which takes
// the next item only once it is back in its idle state.
// Back end work per item: a load runs the 16-step CORDIC; a sample runs three
// multiply stages and two 64-step divisions in one shared divider, or stops
// after the first stage if it fails the scale test; a finish runs one 64-step
// division when there are samples and none without. The divider, one quotient
// bit per cycle, sets the rate.
// Reset clears the run sum, count, flag, queue and result valid flag; the
// transform table holds no value until loaded. When the receiver stalls the
// result waits in the output register; the queue keeps taking items until full.
module intensity_normalize_mean_diff #(
  parameter int NUM_TRANSFORMS = inm_pkg::NUM_TRANSFORMS_DEF,
  parameter int COUNT_BITS     = inm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [16:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [5:0]            norm_index,
  input  logic signed [24:0]    x_offset,
  input  logic signed [24:0]    y_offset,
  input  logic signed [18:0]    theta,
  input  logic signed [19:0]    shear,
  input  logic signed [31:0]    x_scale,
  input  logic signed [31:0]    y_scale,
  input  logic [15:0]           x_raw,
  input  logic [15:0]           y_raw,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [47:0]    mean_difference,
  output logic [COUNT_BITS-1:0] samples_used,
  output logic                  saturated
);
  import inm_pkg::*;

  logic        q_valid, q_ready;
  item_t       q_item;
  logic [16:0] min_abs_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_abs_scale <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_abs_scale <= cfg_data;
    end
  end

  inm_front #(.NUM_TRANSFORMS(NUM_TRANSFORMS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .norm_index(norm_index), .x_offset(x_offset), .y_offset(y_offset),
    .theta(theta), .shear(shear), .x_scale(x_scale), .y_scale(y_scale),
    .x_raw(x_raw), .y_raw(y_raw),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  inm_back #(.NUM_TRANSFORMS(NUM_TRANSFORMS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst(rst), .min_abs_scale(min_abs_scale),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_difference(mean_difference), .samples_used(samples_used),
    .saturated(saturated)
  );

endmodule

@@ dv/tb_intensity_normalize_mean_diff.sv @@
// Testbench for the intensity mean-difference block: scoreboard against an in-bench predictor.
module tb_intensity_normalize_mean_diff;
  import inm_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [5:0] norm_index = '0;
  logic signed [24:0] x_offset = '0;
  logic signed [24:0] y_offset = '0;
  logic signed [18:0] theta = '0;
  logic signed [19:0] shear = '0;
  logic signed [31:0] x_scale = '0;
  logic signed [31:0] y_scale = '0;
  logic [15:0] x_raw = '0;
  logic [15:0] y_raw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] mean_difference;
  logic [23:0] samples_used;
  logic saturated;

  intensity_normalize_mean_diff dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .norm_index(norm_index), .x_offset(x_offset), .y_offset(y_offset),
    .theta(theta), .shear(shear), .x_scale(x_scale), .y_scale(y_scale),
    .x_raw(x_raw), .y_raw(y_raw),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_difference(mean_difference), .samples_used(samples_used),
    .saturated(saturated)
  );

  typedef struct packed {
    logic signed [47:0] mean;
    logic [23:0] used;
    logic sat;
  } mean_t;

  entry_t xf_tab [64];
  bit xf_written [64];
  logic [16:0] scale_floor = '0;
  logic signed [63:0] diff_sum = '0;
  logic [23:0] used_cnt = '0;
  bit ovf_seen = 1'b0;
  mean_t mean_q[$];
  mean_t exp_r;
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result mean=%0d used=%0d sat=%0d", $time,
                 mean_difference, samples_used, saturated);
      end else begin
        exp_r = mean_q.pop_front();
        if (exp_r.mean !== mean_difference) begin
          errors = errors + 1;
          $display("%0t: mean_difference expected %0d actual %0d", $time, exp_r.mean,
                   mean_difference);
        end
        if (exp_r.used !== samples_used) begin
          errors = errors + 1;
          $display("%0t: samples_used expected %0d actual %0d", $time, exp_r.used,
                   samples_used);
        end
        if (exp_r.sat !== saturated) begin
          errors = errors + 1;
          $display("%0t: saturated expected %0d actual %0d", $time, exp_r.sat,
                   saturated);
        end
      end
    end
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void calc_trig(longint ang, output logic signed [17:0] c,
                                    output logic signed [17:0] s);
    longint z, x, y, dx, dy;
    bit flip;
    int atn [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
    z = ang; x = 652032874; y = 0; flip = 0;
    if (z > 102944) begin
      z -= 205887; flip = 1;
    end else if (z < -102944) begin
      z += 205887; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atn[i];
      end else begin
        x += dx; y -= dy; z += atn[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = 18'(fshr(x + 8192, 14));
    s = 18'(fshr(y + 8192, 14));
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic predict_item(input item_t it);
    entry_t t;
    logic signed [17:0] c, s;
    longint tx, ty, rx, ry, sx, xn, yn, d, m;
    bit sat;
    case (it.op)
      OP_LOAD: begin
        t.x_offset = it.x_offset; t.y_offset = it.y_offset;
        calc_trig(longint'(it.theta), c, s);
        t.cos_v = c; t.sin_v = s;
        t.shear = it.shear; t.x_scale = it.x_scale; t.y_scale = it.y_scale;
        xf_tab[it.norm_index] = t;
        xf_written[it.norm_index] = 1;
      end
      OP_SAMPLE: begin
        t = xf_tab[it.norm_index];
        if (absl(longint'(t.x_scale)) > longint'(scale_floor) &&
            absl(longint'(t.y_scale)) > longint'(scale_floor)) begin
          tx = longint'(it.x_raw) * 256 - longint'(t.x_offset);
          ty = longint'(it.y_raw) * 256 - longint'(t.y_offset);
          rx = longint'(t.cos_v) * tx + longint'(t.sin_v) * ty;
          ry = longint'(t.cos_v) * ty - longint'(t.sin_v) * tx;
          sx = rx * 65536 - longint'(t.shear) * ry;
          xn = sx / (longint'(t.x_scale) * 256);
          yn = (ry * 256) / longint'(t.y_scale);
          d = yn - xn;
          if (d > 0 && diff_sum > 64'sh7FFF_FFFF_FFFF_FFFF - d) begin
            diff_sum = 64'sh7FFF_FFFF_FFFF_FFFF; ovf_seen = 1;
          end else if (d < 0 && diff_sum < 64'sh8000_0000_0000_0000 - d) begin
            diff_sum = 64'sh8000_0000_0000_0000; ovf_seen = 1;
          end else begin
            diff_sum += d;
          end
          if (used_cnt == 24'hFFFFFF) ovf_seen = 1;
          else used_cnt++;
        end
      end
      OP_FINISH: begin
        m = 0; sat = ovf_seen;
        if (used_cnt != 0) m = diff_sum / longint'({40'd0, used_cnt});
        if (m > 64'sd140737488355327) begin
          m = 64'sd140737488355327; sat = 1;
        end
        if (m < -64'sd140737488355328) begin
          m = -64'sd140737488355328; sat = 1;
        end
        mean_q.push_back('{48'(m), used_cnt, sat});
        diff_sum = 0; used_cnt = 0; ovf_seen = 0;
      end
      default: ;
    endcase
  endtask

  task automatic drive_item(input logic [1:0] k, input item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= k; norm_index <= it.norm_index;
    x_offset <= it.x_offset; y_offset <= it.y_offset; theta <= it.theta;
    shear <= it.shear; x_scale <= it.x_scale; y_scale <= it.y_scale;
    x_raw <= it.x_raw; y_raw <= it.y_raw;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_item(input item_t it);
    drive_item(it.op, it);
    predict_item(it);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_finish();
    item_t it;
    it = '0; it.op = OP_FINISH;
    it.norm_index = 6'($urandom); it.x_raw = 16'($urandom);
    send_item(it);
  endtask

  task automatic write_floor(input logic [16:0] v);
    send_finish();
    wait_results();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    scale_floor = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t load_item(input logic [5:0] idx, input logic signed [18:0] th,
                                      input logic signed [31:0] xs,
                                      input logic signed [31:0] ys);
    item_t it;
    it = '0;
    it.op = OP_LOAD; it.norm_index = idx; it.theta = th;
    it.x_offset = 25'($urandom); it.y_offset = 25'($urandom);
    it.shear = 20'($urandom); it.x_scale = xs; it.y_scale = ys;
    it.x_raw = 16'($urandom); it.y_raw = 16'($urandom);
    return it;
  endfunction

  function automatic logic signed [31:0] rand_scale();
    logic signed [31:0] v;
    case ($urandom_range(4))
      0: v = $signed($urandom);
      1: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: v = 32'sd65536;
      3: v = $signed(32'($urandom_range(70000)));
      default: v = $signed(32'($urandom_range(1048576))) + 32'sd1;
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  function automatic item_t rand_load();
    int th;
    th = int'($urandom_range(411774)) - 205887;
    return load_item(6'($urandom_range(63)), 19'(th), rand_scale(), rand_scale());
  endfunction

  function automatic item_t rand_sample();
    item_t it;
    int idx;
    it = '0;
    do idx = int'($urandom_range(63)); while (!xf_written[idx]);
    it.op = OP_SAMPLE; it.norm_index = 6'(idx);
    it.x_raw = 16'($urandom); it.y_raw = 16'($urandom);
    it.x_offset = 25'($urandom); it.theta = 19'($urandom);
    it.x_scale = 32'($urandom); it.y_scale = 32'($urandom);
    return it;
  endfunction

  task automatic send_spare();
    item_t it;
    it = rand_sample();
    drive_item(KIND_SPARE, it);
  endtask

  task automatic sample_at(input logic [5:0] idx, input logic [15:0] xr,
                           input logic [15:0] yr);
    item_t it;
    it = rand_sample();
    it.norm_index = idx; it.x_raw = xr; it.y_raw = yr;
    send_item(it);
  endtask

  task automatic test_empty_finish();
    send_finish();
    send_finish();
  endtask

  task automatic test_directed();
    item_t it;
    send_item(load_item(6'd0, 19'sd0, 32'sd65536, 32'sd65536));
    send_item(load_item(6'd1, 19'sd205887, 32'sh7FFFFFFF, 32'sh80000000));
    send_item(load_item(6'd2, -19'sd205887, 32'sd1, -32'sd1));
    send_item(load_item(6'd3, 19'sd102945, 32'sd0, 32'sd65536));
    send_item(load_item(6'd4, -19'sd102945, 32'sd131072, -32'sd65537));
    it = load_item(6'd5, 19'sd100, 32'sd2, 32'sd2);
    it.x_offset = 25'sh0FFFFFF; it.y_offset = -25'sh1000000;
    it.shear = -20'sd524288;
    send_item(it);
    it = load_item(6'd6, -19'sd100, 32'sd3, 32'sd3);
    it.x_offset = -25'sh1000000; it.y_offset = 25'sh0FFFFFF; it.shear = 20'sd524287;
    send_item(it);
    for (int i = 0; i < 7; i++) begin
      sample_at(6'(i), i[0] ? 16'hFFFF : 16'h0000, (i % 3 != 0) ? 16'h0000 : 16'hFFFF);
    end
    send_spare();
    send_finish();
    for (int i = 0; i < 20; i++) send_item(rand_sample());
    send_spare();
    send_finish();
  endtask

  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = int'($urandom_range(99));
      if (r < 15) send_item(rand_load());
      else if (r < 90) send_item(rand_sample());
      else if (r < 97) send_finish();
      else send_spare();
    end
  endtask

  task automatic test_pressure();
    for (int i = 0; i < 10; i++) send_item(rand_sample());
    send_finish();
    wait_results();
    send_finish();
  endtask

  task automatic test_saturation();
    item_t it;
    it = load_item(6'd30, 19'sd0, 32'sd1, -32'sd1);
    it.x_offset = -25'sh1000000; it.y_offset = -25'sh1000000; it.shear = -20'sd524288;
    send_item(it);
    it = load_item(6'd31, 19'sd0, -32'sd1, 32'sd1);
    it.x_offset = -25'sh1000000; it.y_offset = -25'sh1000000; it.shear = -20'sd524288;
    send_item(it);
    for (int i = 0; i < 15; i++) sample_at(6'd30, 16'hFFFF, 16'hFFFF);
    send_finish();
    for (int i = 0; i < 15; i++) sample_at(6'd31, 16'hFFFF, 16'hFFFF);
    send_finish();
    for (int i = 0; i < 10; i++) begin
      sample_at(i[0] ? 6'd31 : 6'd30, 16'($urandom), 16'($urandom));
    end
    send_finish();
  endtask

  task automatic test_threshold();
    write_floor(17'd65536);
    send_item(load_item(6'd20, 19'sd0, 32'sd65536, 32'sd131072));
    send_item(load_item(6'd21, 19'sd51472, 32'sd65537, -32'sd65537));
    send_item(load_item(6'd22, 19'sd0, -32'sd65536, 32'sd131072));
    send_item(load_item(6'd23, 19'sd0, 32'sd131072, 32'sd65536));
    for (int i = 0; i < 16; i++) begin
      sample_at(6'(20 + (i % 4)), 16'($urandom), 16'($urandom));
    end
    send_finish();
    write_floor(17'd0);
    for (int i = 0; i < 6; i++) begin
      sample_at(i[0] ? 6'd3 : 6'd2, 16'($urandom), 16'($urandom));
    end
    send_finish();
  endtask

  initial begin
    foreach (xf_written[i]) xf_written[i] = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle = 16; recv_idle = 83;
    test_empty_finish();
    test_directed();
    test_random(150);
    test_pressure();
    send_idle = 83; recv_idle = 16;
    test_saturation();
    test_random(150);
    send_idle = 0; recv_idle = 0;
    test_threshold();
    test_random(180);
    send_finish();
    wait_results();
    repeat (20) @(negedge clk);
    if (errors == 0 && mean_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ files.f @@
hdl/inm_pkg.sv
hdl/inm_front.sv
hdl/inm_cordic.sv
hdl/inm_div.sv
hdl/inm_back.sv
hdl/intensity_normalize_mean_diff.sv
dv/tb_intensity_normalize_mean_diff.sv
